>>> rtl/core/rstu_pkg.sv
`timescale 1ns / 1ps

package rstu_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int MAX_COLUMNS = 8;

  localparam int RANK_W  = $clog2(MAX_ENTRIES);
  localparam int COL_W   = $clog2(MAX_COLUMNS);
  localparam int ROWS_W  = RANK_W + 1;
  localparam int CELL_AW = RANK_W + COL_W;
  localparam int PTS_W   = 16;
  localparam int TOT_W   = 32;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_RANK_ERR = 2'd1,
    STATUS_COL_ERR  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RD_SLOT,
    S_UPD,
    S_ABOVE,
    S_CMP,
    S_FIN,
    S_DONE
  } fsm_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;    // capture input word
    logic rd_rank;    // read rank table at the requested rank
    logic cap_slot;   // latch slot, read its total and cell
    logic upd;        // write saturated cell and total
    logic rd_cur_m1;  // read rank table one above current rank
    logic cap_above;  // latch neighbour slot, read its total
    logic rd_cur_m2;  // read rank table two above (overlapped with a move)
    logic move;       // neighbour drops one place, current rank steps up
    logic place;      // park the updated slot at current rank
    logic load_out;   // load result word
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic err;
    logic cur_zero;
    logic cur_one;
    logic move_ok;
    logic out_free;
  } sts_t;

  function automatic logic signed [TOT_W-1:0] sat_add(
    input logic signed [TOT_W-1:0] a,
    input logic signed [PTS_W-1:0] b
  );
    logic signed [TOT_W:0] s;
    logic signed [TOT_W-1:0] res;
    s = {a[TOT_W-1], a} + {{(TOT_W+1-PTS_W){b[PTS_W-1]}}, b};
    if (s[TOT_W] != s[TOT_W-1]) begin
      res = s[TOT_W] ? {1'b1, {(TOT_W-1){1'b0}}} : {1'b0, {(TOT_W-1){1'b1}}};
    end else begin
      res = s[TOT_W-1:0];
    end
    return res;
  endfunction

endpackage

>>> rtl/core/rstu_ctrl.sv
`timescale 1ns / 1ps

module rstu_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rstu_pkg::sts_t sts,
  output rstu_pkg::cmd_t cmd
);
  import rstu_pkg::*;

  fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.err) begin
          state_nxt = S_DONE;
        end else begin
          cmd.rd_rank = 1'b1;
          state_nxt   = S_RD_SLOT;
        end
      end
      S_RD_SLOT: begin
        cmd.cap_slot = 1'b1;
        state_nxt    = S_UPD;
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        if (sts.cur_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.rd_cur_m1 = 1'b1;
          state_nxt     = S_ABOVE;
        end
      end
      S_ABOVE: begin
        cmd.cap_above = 1'b1;
        state_nxt     = S_CMP;
      end
      S_CMP: begin
        if (sts.move_ok) begin
          cmd.move = 1'b1;
          if (sts.cur_one) begin
            state_nxt = S_FIN;
          end else begin
            cmd.rd_cur_m2 = 1'b1;
            state_nxt     = S_ABOVE;
          end
        end else begin
          cmd.place = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_FIN: begin
        cmd.place = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/rstu_dp.sv
`timescale 1ns / 1ps

module rstu_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  rstu_pkg::cmd_t                        cmd,
  output rstu_pkg::sts_t                        sts,
  input  logic                                  cfg_valid,
  input  logic [rstu_pkg::ROWS_W-1:0]           cfg_rows_in_use,
  input  logic [rstu_pkg::RANK_W-1:0]           in_rank_position,
  input  logic [rstu_pkg::COL_W-1:0]            in_column,
  input  logic signed [rstu_pkg::PTS_W-1:0]     in_points,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0]                            out_status,
  output logic [rstu_pkg::RANK_W-1:0]           out_new_rank,
  output logic signed [rstu_pkg::TOT_W-1:0]     out_new_total
);
  import rstu_pkg::*;

  logic [ROWS_W-1:0]        rows_in_use_r;
  logic [ROWS_W-1:0]        used;
  logic [RANK_W-1:0]        rank_r, cur_r, slot_r, above_r;
  logic [COL_W-1:0]         col_r;
  logic signed [PTS_W-1:0]  pts_r;
  logic signed [TOT_W-1:0]  total_r;
  status_t                  code_r, code_nxt;

  // rank table, totals, cells; valid bits give the reset contents
  logic [RANK_W-1:0]        r2s_mem_r [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]   r2s_vld_r;
  logic [RANK_W-1:0]        r2s_q;
  logic signed [TOT_W-1:0]  tot_mem_r [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]   tot_vld_r;
  logic signed [TOT_W-1:0]  tot_q;
  logic signed [TOT_W-1:0]  cell_mem_r [MAX_ENTRIES*MAX_COLUMNS];
  logic [MAX_ENTRIES*MAX_COLUMNS-1:0] cell_vld_r;
  logic signed [TOT_W-1:0]  cell_q;

  logic                     r2s_rd, r2s_wr;
  logic [RANK_W-1:0]        r2s_ra, r2s_wd;
  logic [CELL_AW-1:0]       cell_ra, cell_wa;
  logic signed [TOT_W-1:0]  tot_sum, cell_sum;
  logic                     out_valid_r;
  status_t                  out_status_r;
  logic [RANK_W-1:0]        out_rank_r;
  logic signed [TOT_W-1:0]  out_total_r;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_in_use_r <= ROWS_W'(MAX_ENTRIES);
    end else if (cfg_valid) begin
      rows_in_use_r <= cfg_rows_in_use;
    end
  end

  assign used = (rows_in_use_r > ROWS_W'(MAX_ENTRIES)) ? ROWS_W'(MAX_ENTRIES) : rows_in_use_r;

  always_comb begin
    if ({1'b0, in_rank_position} >= used) begin
      code_nxt = STATUS_RANK_ERR;
    end else if ((COL_W+1)'(in_column) >= (COL_W+1)'(MAX_COLUMNS)) begin
      code_nxt = STATUS_COL_ERR;
    end else begin
      code_nxt = STATUS_OK;
    end
  end

  assign tot_sum  = sat_add(tot_q, pts_r);
  assign cell_sum = sat_add(cell_q, pts_r);

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      rank_r  <= in_rank_position;
      cur_r   <= in_rank_position;
      col_r   <= in_column;
      pts_r   <= in_points;
      code_r  <= code_nxt;
      total_r <= '0;
    end
    if (cmd.cap_slot) begin
      slot_r <= r2s_q;
    end
    if (cmd.cap_above) begin
      above_r <= r2s_q;
    end
    if (cmd.upd) begin
      total_r <= tot_sum;
    end
    if (cmd.move) begin
      cur_r <= cur_r - RANK_W'(1);
    end
  end

  // rank table port
  always_comb begin
    r2s_ra = rank_r;
    if (cmd.rd_cur_m1) begin
      r2s_ra = cur_r - RANK_W'(1);
    end else if (cmd.rd_cur_m2) begin
      r2s_ra = cur_r - RANK_W'(2);
    end
  end

  assign r2s_rd = cmd.rd_rank | cmd.rd_cur_m1 | cmd.rd_cur_m2;
  assign r2s_wr = cmd.move | cmd.place;
  assign r2s_wd = cmd.move ? above_r : slot_r;

  always_ff @(posedge clk) begin
    if (r2s_wr) begin
      r2s_mem_r[cur_r] <= r2s_wd;
    end
    if (r2s_rd) begin
      r2s_q <= r2s_vld_r[r2s_ra] ? r2s_mem_r[r2s_ra] : r2s_ra;
    end
  end

  // totals and cells
  assign cell_ra = {r2s_q, col_r};
  assign cell_wa = {slot_r, col_r};

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      tot_mem_r[slot_r]   <= tot_sum;
      cell_mem_r[cell_wa] <= cell_sum;
    end
    if (cmd.cap_slot || cmd.cap_above) begin
      tot_q <= tot_vld_r[r2s_q] ? tot_mem_r[r2s_q] : '0;
    end
    if (cmd.cap_slot) begin
      cell_q <= cell_vld_r[cell_ra] ? cell_mem_r[cell_ra] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r2s_vld_r  <= '0;
      tot_vld_r  <= '0;
      cell_vld_r <= '0;
    end else begin
      if (r2s_wr) begin
        r2s_vld_r[cur_r] <= 1'b1;
      end
      if (cmd.upd) begin
        tot_vld_r[slot_r]   <= 1'b1;
        cell_vld_r[cell_wa] <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= code_r;
      out_rank_r   <= cur_r;
      out_total_r  <= total_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_new_rank  = out_rank_r;
  assign out_new_total = out_total_r;

  always_comb begin
    sts          = '0;
    sts.err      = (code_r != STATUS_OK);
    sts.cur_zero = (cur_r == '0);
    sts.cur_one  = (cur_r == RANK_W'(1));
    sts.move_ok  = (total_r > tot_q);
    sts.out_free = !out_valid_r || out_ready;
  end

endmodule

>>> rtl/core/ranked_score_table_update.sv
`timescale 1ns / 1ps

// Channel  Dir  Ports                                             Notes
// -------  ---  ------------------------------------------------  ---------------------
// cfg      in   cfg_valid cfg_ready cfg_rows_in_use                 ready always high
// in       in   in_valid in_ready in_rank_position in_column in_points  one word in flight
// out      out  out_valid out_ready out_status out_new_rank out_new_total  registered
//
// Each word is checked first; a rank or column error goes straight to the
// result. Otherwise the entry's slot is read and its cell and total updated,
// then it climbs one place per step while its new total strictly beats the
// neighbour's, until it reaches the top; each climb step reads the neighbour
// slot, then its total, from registered-read memories.
// Reset (rst_n low, synchronous) empties all stores at once through per-entry
// valid bits; no clearing sweep. The result register frees the controller,
// so a new word is taken while the last result still waits on out_ready;
// a held result only stalls the next word at its final step.

module ranked_score_table_update (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rstu_pkg::ROWS_W-1:0]        cfg_rows_in_use,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [rstu_pkg::RANK_W-1:0]        in_rank_position,
  input  logic [rstu_pkg::COL_W-1:0]         in_column,
  input  logic signed [rstu_pkg::PTS_W-1:0]  in_points,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_status,
  output logic [rstu_pkg::RANK_W-1:0]        out_new_rank,
  output logic signed [rstu_pkg::TOT_W-1:0]  out_new_total
);
  import rstu_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // config writes must land only while idle; the block does not enforce it and gives no back-pressure
  assign cfg_ready = 1'b1;

  rstu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rstu_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_valid        (cfg_valid),
    .cfg_rows_in_use  (cfg_rows_in_use),
    .in_rank_position (in_rank_position),
    .in_column        (in_column),
    .in_points        (in_points),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_new_rank     (out_new_rank),
    .out_new_total    (out_new_total)
  );

endmodule

>>> rtl/core/rstu_checker.sv
`timescale 1ns / 1ps

module rstu_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               cfg_valid,
  input logic                               cfg_ready,
  input logic [rstu_pkg::ROWS_W-1:0]        cfg_rows_in_use,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic [rstu_pkg::RANK_W-1:0]        in_rank_position,
  input logic [rstu_pkg::COL_W-1:0]         in_column,
  input logic signed [rstu_pkg::PTS_W-1:0]  in_points,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [1:0]                         out_status,
  input logic [rstu_pkg::RANK_W-1:0]        out_new_rank,
  input logic signed [rstu_pkg::TOT_W-1:0]  out_new_total
);
  import rstu_pkg::*;

  // held result keeps its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_new_total) && $stable(out_new_rank))
    else $error("result word changed while stalled");

  // one word at a time: taking a word drops ready for at least the check step
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one in flight");

  // rejected words report a zero total
  a_err_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_RANK_ERR || out_status == STATUS_COL_ERR)
      |-> out_new_total == '0)
    else $error("error result carries a total");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind ranked_score_table_update rstu_checker u_rstu_checker (.*);
